>>> design/ppu_pkg.sv
package ppu_pkg;

  localparam int PARTICLE_COUNT_DEF = 32;
  localparam int SLOT_W = 6;
  localparam int POS_W = 24;
  localparam int DT_W = 16;
  localparam int LIFE_W = 17;
  localparam int SHADE_W = 9;
  localparam int ALPHA_W = 19;
  localparam int RAW_W = 7;

  localparam logic [LIFE_W-1:0] LIFE_ONE = 17'd65536;
  localparam logic signed [ALPHA_W-1:0] ALPHA_ONE = 19'sd65536;
  localparam logic signed [ALPHA_W-1:0] ALPHA_FLOOR = -19'sd262144;
  localparam logic [SHADE_W-1:0] SHADE_ONE = 9'd256;
  localparam logic [SHADE_W-1:0] SHADE_BASE = 9'd128;
  localparam logic [RAW_W-1:0] RAW_MAX = 7'd99;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_REPORT = 1'b1;
  localparam logic ACT_SPAWN = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic [LIFE_W-1:0] life;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [SHADE_W-1:0] shade;
    logic signed [ALPHA_W-1:0] alpha;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{life: '0, px: '0, py: '0, vx: '0, vy: '0,
                                     shade: SHADE_ONE, alpha: ALPHA_ONE};

  function automatic logic [RAW_W-1:0] sat_raw(input logic [RAW_W-1:0] r);
    return (r > RAW_MAX) ? RAW_MAX : r;
  endfunction

  // (raw-50)*256/10 toward zero; divide by 10 through a reciprocal
  function automatic logic signed [11:0] jitter_of(input logic [RAW_W-1:0] raw);
    logic signed [7:0] d;
    logic [6:0] mag;
    logic [13:0] m;
    logic [29:0] p;
    logic [11:0] q;
    d = signed'({1'b0, sat_raw(raw)}) - 8'sd50;
    mag = d[7] ? 7'(-d) : 7'(d);
    m = {mag, 7'd0} << 1;
    p = 30'(m) * 30'd52429;
    q = 12'(p >> 19);
    return d[7] ? -signed'(q) : signed'(q);
  endfunction

  function automatic logic [SHADE_W-1:0] shade_of(input logic [RAW_W-1:0] raw);
    logic [14:0] m;
    logic [31:0] p;
    m = {sat_raw(raw), 8'd0};
    p = 32'(m) * 32'd41944;
    return SHADE_BASE + SHADE_W'(p >> 22);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    if (v > 26'sd8388607) return 24'sd8388607;
    if (v < -26'sd8388608) return -24'sd8388608;
    return v[POS_W-1:0];
  endfunction

  // |v|/10 truncated, by reciprocal multiply
  function automatic logic [19:0] mag_div10(input logic signed [POS_W-1:0] v);
    logic [POS_W-1:0] mag;
    logic [55:0] p;
    mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
    p = 56'(mag) * 56'h0CCCCCCCD;
    return 20'(p >> 35);
  endfunction

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SPCALC = 7'b0000100,
    S_SPWR   = 7'b0001000,
    S_TRD    = 7'b0010000,
    S_TMUL   = 7'b0100000,
    S_TWB    = 7'b1000000
  } state_t;

endpackage

>>> design/ppu_mem.sv
module ppu_mem
  import ppu_pkg::*;
#(
  parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF,
  parameter int IDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data
);

  entry_t mem [PARTICLE_COUNT];
  logic [PARTICLE_COUNT-1:0] valid_r;
  entry_t rd_q_r;
  logic rd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q_r <= mem[rd_idx];
  end

  // unwritten entries read as the reset entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      rd_v_r <= valid_r[rd_idx];
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : ENTRY_RESET;

endmodule

>>> design/particle_pool_update_unit.sv
// Particle pool update unit. Holds PARTICLE_COUNT particles in one
// synchronous memory and serves two kinds of item. A spawn item scans the
// live flags one slot per cycle, next-fit from the last used slot with one
// wrap (slot 0 is reused when the pool is full), loads the slot and returns
// one acknowledgement. A tick item walks every slot through a read, multiply
// and write-back sequence, set by the single memory port and the velocity*dt
// multipliers, and returns one report per slot with last set on the final
// slot; each write-back waits out any output stall. One item is in work at a
// time; the output register lets a new item enter while a result waits.
module particle_pool_update_unit
  import ppu_pkg::*;
#(
  parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [DT_W-1:0]           in_dt,
  input  logic signed [POS_W-1:0]   in_source_x,
  input  logic signed [POS_W-1:0]   in_source_y,
  input  logic signed [POS_W-1:0]   in_source_vel_x,
  input  logic signed [POS_W-1:0]   in_source_vel_y,
  input  logic signed [POS_W-1:0]   in_offset_x,
  input  logic signed [POS_W-1:0]   in_offset_y,
  input  logic [RAW_W-1:0]          in_jitter_raw,
  input  logic [RAW_W-1:0]          in_shade_raw,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic [SLOT_W-1:0]         out_slot,
  output logic                      out_alive,
  output logic signed [POS_W-1:0]   out_pos_x,
  output logic signed [POS_W-1:0]   out_pos_y,
  output logic [SHADE_W-1:0]        out_shade,
  output logic signed [ALPHA_W-1:0] out_alpha,
  output logic                      out_last
);

  localparam int IDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARTICLE_COUNT - 1);

  state_t state_r, state_nxt;

  // captured item
  logic [DT_W-1:0]         dt_r;
  logic signed [POS_W-1:0] sx_r, sy_r, svx_r, svy_r, ox_r, oy_r;
  logic [RAW_W-1:0]        jr_r, sr_r;

  logic [SLOT_W-1:0]       search_start_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        scan_cnt_r;
  logic [PARTICLE_COUNT-1:0] alive_r;

  // spawn results
  logic signed [POS_W-1:0] spx_r, spy_r;
  logic [19:0]             qvx_r, qvy_r;
  logic                    vx_neg_r, vy_neg_r;
  logic [SHADE_W-1:0]      sshade_r;

  // tick results
  entry_t                  ent_r;
  logic [LIFE_W-1:0]       life_n_r;
  logic signed [40:0]      prod_x_r, prod_y_r;

  entry_t                  rd_data;
  entry_t                  wr_data;
  logic                    wr_en;
  logic [IDX_W-1:0]        rd_idx;

  logic in_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  ppu_mem #(.PARTICLE_COUNT(PARTICLE_COUNT), .IDX_W(IDX_W)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (idx_r),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  assign rd_idx = idx_r;

  // truncate product/65536 toward zero
  function automatic logic signed [POS_W:0] q16(input logic signed [40:0] p);
    logic signed [40:0] a;
    a = p[40] ? p + 41'sd65535 : p;
    return 25'(a >>> 16);
  endfunction

  logic signed [POS_W-1:0] tpx, tpy;
  logic signed [ALPHA_W+1:0] a_sub;
  logic signed [ALPHA_W-1:0] talpha;
  logic [17:0] fade;
  logic t_alive;
  entry_t tick_ent, spawn_ent;

  always_comb begin
    fade   = 18'((19'(dt_r) * 19'd5) >> 1);
    tpx    = sat_pos(26'(ent_r.px) - 26'(q16(prod_x_r)));
    tpy    = sat_pos(26'(ent_r.py) - 26'(q16(prod_y_r)));
    a_sub  = 21'(ent_r.alpha) - signed'({3'b0, fade});
    talpha = (a_sub < 21'(ALPHA_FLOOR)) ? ALPHA_FLOOR : a_sub[ALPHA_W-1:0];
    t_alive = (life_n_r != '0);
    tick_ent = ent_r;
    tick_ent.life = life_n_r;
    if (t_alive) begin
      tick_ent.px = tpx;
      tick_ent.py = tpy;
      tick_ent.alpha = talpha;
    end
    spawn_ent.life  = LIFE_ONE;
    spawn_ent.px    = spx_r;
    spawn_ent.py    = spy_r;
    spawn_ent.vx    = vx_neg_r ? -signed'(POS_W'(qvx_r)) : signed'(POS_W'(qvx_r));
    spawn_ent.vy    = vy_neg_r ? -signed'(POS_W'(qvy_r)) : signed'(POS_W'(qvy_r));
    spawn_ent.shade = sshade_r;
    spawn_ent.alpha = ALPHA_ONE;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_data = tick_ent;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_action == ACT_SPAWN) ? S_SEARCH : S_TRD;
      end
      S_SEARCH: begin
        if (!alive_r[idx_r] || scan_cnt_r == IDX_LAST) state_nxt = S_SPCALC;
      end
      S_SPCALC: state_nxt = S_SPWR;
      S_SPWR: begin
        wr_data = spawn_ent;
        if (out_free) begin
          wr_en = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TRD: state_nxt = S_TMUL;
      S_TMUL: state_nxt = S_TWB;
      S_TWB: begin
        if (out_free) begin
          wr_en = 1'b1;
          state_nxt = (idx_r == IDX_LAST) ? S_IDLE : S_TRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      search_start_r <= '0;
      alive_r <= '0;
      idx_r <= '0;
      scan_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a new result with each write-back, drop one that was taken
      if (wr_en) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          scan_cnt_r <= '0;
          if (in_acc) begin
            if (in_action == ACT_SPAWN) begin
              // an out-of-range start falls back to slot 0
              idx_r <= ({1'b0, search_start_r} < 7'(PARTICLE_COUNT)) ?
                       search_start_r[IDX_W-1:0] : '0;
            end else begin
              idx_r <= '0;
            end
          end
        end
        S_SEARCH: begin
          if (!alive_r[idx_r]) begin
            search_start_r <= SLOT_W'(idx_r);
          end else if (scan_cnt_r == IDX_LAST) begin
            // pool full: reuse slot 0
            idx_r <= '0;
            search_start_r <= '0;
          end else begin
            idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
        end
        S_SPWR: begin
          if (out_free) begin
            alive_r[idx_r] <= 1'b1;
          end
        end
        S_TWB: begin
          if (out_free) begin
            alive_r[idx_r] <= t_alive;
            if (idx_r != IDX_LAST) idx_r <= idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r  <= in_dt;
      sx_r  <= in_source_x;
      sy_r  <= in_source_y;
      svx_r <= in_source_vel_x;
      svy_r <= in_source_vel_y;
      ox_r  <= in_offset_x;
      oy_r  <= in_offset_y;
      jr_r  <= in_jitter_raw;
      sr_r  <= in_shade_raw;
    end
    if (state_r == S_SPCALC) begin
      spx_r <= sat_pos(26'(sx_r) + 26'(jitter_of(jr_r)) + 26'(ox_r));
      spy_r <= sat_pos(26'(sy_r) + 26'(jitter_of(jr_r)) + 26'(oy_r));
      qvx_r <= mag_div10(svx_r);
      qvy_r <= mag_div10(svy_r);
      vx_neg_r <= svx_r[POS_W-1];
      vy_neg_r <= svy_r[POS_W-1];
      sshade_r <= shade_of(sr_r);
    end
    if (state_r == S_TMUL) begin
      ent_r <= rd_data;
      life_n_r <= (rd_data.life > LIFE_W'(dt_r)) ? rd_data.life - LIFE_W'(dt_r) : '0;
      prod_x_r <= 41'(rd_data.vx) * 41'(signed'({1'b0, dt_r}));
      prod_y_r <= 41'(rd_data.vy) * 41'(signed'({1'b0, dt_r}));
    end
    if (state_r == S_SPWR && out_free) begin
      out_kind  <= KIND_SPAWN;
      out_slot  <= SLOT_W'(idx_r);
      out_alive <= 1'b1;
      out_pos_x <= spawn_ent.px;
      out_pos_y <= spawn_ent.py;
      out_shade <= spawn_ent.shade;
      out_alpha <= spawn_ent.alpha;
      out_last  <= 1'b1;
    end
    if (state_r == S_TWB && out_free) begin
      out_kind  <= KIND_REPORT;
      out_slot  <= SLOT_W'(idx_r);
      out_alive <= t_alive;
      out_pos_x <= tick_ent.px;
      out_pos_y <= tick_ent.py;
      out_shade <= tick_ent.shade;
      out_alpha <= tick_ent.alpha;
      out_last  <= (idx_r == IDX_LAST);
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_REPORT && out_last) |->
      out_slot == SLOT_W'(PARTICLE_COUNT - 1))
    else $error("tick report marked last on wrong slot");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("accepted item not started");

  a_spawn_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_SPAWN) |-> (out_alive && out_last))
    else $error("spawn acknowledgement malformed");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

// Holds the expected particle reports and the mirrored particle pool.
class pool_scoreboard;
  localparam int NSLOT = 32;
  longint life[NSLOT];
  longint px[NSLOT];
  longint py[NSLOT];
  longint vx[NSLOT];
  longint vy[NSLOT];
  longint shade[NSLOT];
  longint alpha[NSLOT];
  int unsigned next_start;
  logic [84:0] pending_reports[$];
  int mismatches;

  function new();
    for (int i = 0; i < NSLOT; i++) begin
      life[i] = 0; px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
      shade[i] = 256; alpha[i] = 65536;
    end
    next_start = 0;
    mismatches = 0;
  endfunction

  function longint clamp_pos(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function void queue_report(bit kind, int k, bit last);
    logic [84:0] r;
    r = {kind, 6'(k), life[k] > 0, 24'(px[k]), 24'(py[k]), 9'(shade[k]),
         19'(alpha[k]), last};
    pending_reports = {pending_reports, r};
  endfunction

  // Mirror one accepted item and queue the reports it causes.
  function void note_item(bit action, logic [15:0] dt, logic signed [23:0] sx,
                          logic signed [23:0] sy, logic signed [23:0] svx,
                          logic signed [23:0] svy, logic signed [23:0] ox,
                          logic signed [23:0] oy, logic [6:0] jr_in,
                          logic [6:0] sr_in);
    longint jr, sr, jit, d, fade, l;
    int k, s;
    if (action == ppu_pkg::ACT_SPAWN) begin
      s = (next_start < NSLOT) ? next_start : 0;
      k = -1;
      for (int i = s; i < NSLOT && k < 0; i++) if (life[i] <= 0) k = i;
      for (int i = 0; i < s && k < 0; i++) if (life[i] <= 0) k = i;
      if (k < 0) k = 0;
      next_start = k;
      jr = (jr_in > 99) ? 99 : jr_in;
      sr = (sr_in > 99) ? 99 : sr_in;
      jit = ((jr - 50) * 256) / 10;
      px[k] = clamp_pos(longint'(sx) + jit + longint'(ox));
      py[k] = clamp_pos(longint'(sy) + jit + longint'(oy));
      vx[k] = longint'(svx) / 10;
      vy[k] = longint'(svy) / 10;
      shade[k] = 128 + (sr * 256) / 100;
      alpha[k] = 65536;
      life[k] = 65536;
      queue_report(ppu_pkg::KIND_SPAWN, k, 1'b1);
    end else begin
      d = dt;
      fade = (5 * d) >> 1;
      for (int i = 0; i < NSLOT; i++) begin
        l = life[i] - d;
        if (l < 0) l = 0;
        life[i] = l;
        if (l > 0) begin
          px[i] = clamp_pos(px[i] - (vx[i] * d) / 65536);
          py[i] = clamp_pos(py[i] - (vy[i] * d) / 65536);
          alpha[i] = (alpha[i] - fade < -262144) ? -262144 : alpha[i] - fade;
        end
        queue_report(ppu_pkg::KIND_REPORT, i, i == NSLOT - 1);
      end
    end
  endfunction

  function void check_report(logic [84:0] got);
    logic [84:0] want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected report %h", got);
      return;
    end
    want = pending_reports.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report mismatch: expected %h got %h", want, got);
    end
  endfunction
endclass

module testbench;
  import ppu_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_action;
  logic [DT_W-1:0] in_dt;
  logic signed [POS_W-1:0] in_source_x, in_source_y, in_source_vel_x, in_source_vel_y;
  logic signed [POS_W-1:0] in_offset_x, in_offset_y;
  logic [RAW_W-1:0] in_jitter_raw, in_shade_raw;
  logic out_valid, out_stall, out_kind, out_alive, out_last;
  logic [SLOT_W-1:0] out_slot;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y;
  logic [SHADE_W-1:0] out_shade;
  logic signed [ALPHA_W-1:0] out_alpha;

  // Idle and stall percentages, changed per phase; hold_off forces a long output stall.
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_off;
  pool_scoreboard pool;

  particle_pool_update_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Drive the stall randomly; the hold-off keeps it high regardless.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
  end

  // Check every accepted report.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pool.check_report({out_kind, out_slot, out_alive, out_pos_x, out_pos_y,
                         out_shade, out_alpha, out_last});
  end

  // Offer one item and hold it until accepted; note it in the pool mirror.
  // Valid drops only while the sender idles, so a new item follows directly.
  task automatic send_item(bit action, logic [15:0] dt, logic [23:0] sx,
                           logic [23:0] sy, logic [23:0] svx, logic [23:0] svy,
                           logic [23:0] ox, logic [23:0] oy, logic [6:0] jr,
                           logic [6:0] sr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_dt <= dt;
    in_source_x <= sx; in_source_y <= sy;
    in_source_vel_x <= svx; in_source_vel_y <= svy;
    in_offset_x <= ox; in_offset_y <= oy;
    in_jitter_raw <= jr; in_shade_raw <= sr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.note_item(action, dt, sx, sy, svx, svy, ox, oy, jr, sr);
  endtask

  // Spawn with random content; values span the full range of each field.
  task automatic spawn_random();
    send_item(ACT_SPAWN, 16'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              7'($urandom), 7'($urandom));
  endtask

  task automatic tick_random();
    logic [15:0] dt;
    dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
    send_item(ACT_TICK, dt, 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom), 7'($urandom),
              7'($urandom));
  endtask

  initial begin
    pool = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_action = 1'b0; in_dt = '0;
    in_source_x = '0; in_source_y = '0; in_source_vel_x = '0; in_source_vel_y = '0;
    in_offset_x = '0; in_offset_y = '0; in_jitter_raw = '0; in_shade_raw = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of positions and velocity, raw values at and above 99,
    // saturation both ways, tick with zero dt and a tick that kills everything.
    send_item(ACT_SPAWN, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
              24'h7FFFFF, 24'h800000, 7'd99, 7'd99);
    send_item(ACT_SPAWN, 16'd0, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
              24'h800000, 24'h7FFFFF, 7'd0, 7'd0);
    send_item(ACT_SPAWN, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
              7'd127, 7'd127);
    send_item(ACT_SPAWN, 16'd0, 24'd100, -24'd100, 24'd9, -24'd9, 24'd0, 24'd0,
              7'd50, 7'd100);
    send_item(ACT_TICK, 16'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
              24'h7FFFFF, 24'h7FFFFF, 7'd127, 7'd127);
    send_item(ACT_TICK, 16'd30000, '0, '0, '0, '0, '0, '0, '0, '0);
    send_item(ACT_TICK, 16'd1, '0, '0, '0, '0, '0, '0, '0, '0);
    send_item(ACT_TICK, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0);
    // Fill the pool past full so slot 0 is reused, with a long output hold-off.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 34; i++) spawn_random();
    join
    send_item(ACT_TICK, 16'd20000, '0, '0, '0, '0, '0, '0, '0, '0);

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1 || ph == 3) ? 69 : 0;
      receiver_stall_pct = (ph == 2 || ph == 3) ? 69 : 0;
      if (ph == 3) begin
        sender_idle_pct = 6;
        receiver_stall_pct = 6;
      end
      for (int n = 0; n < 17; n++) begin
        if ($urandom_range(99) < 65) spawn_random();
        else tick_random();
      end
    end

    in_valid <= 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    while (pool.pending_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pool.mismatches == 0 && pool.pending_reports.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> particle_pool_update_unit.f
design/ppu_pkg.sv
design/ppu_mem.sv
design/particle_pool_update_unit.sv
bench/testbench.sv
